[design/edpp_pkg.sv]
// Shared types, codes and helpers for the error diffusion pixel packer.
package edpp_pkg;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned LANE_W   = 3;
  localparam int unsigned ERR_W    = NUM_CH * LANE_W;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned FMT_W    = 2;
  localparam int unsigned IMG_WW   = 11;
  localparam int unsigned IMG_HW   = 16;

  // Diffusion factors, in sixteenths.
  localparam logic [2:0] F_RIGHT  = 3'd7;
  localparam logic [2:0] F_BLEFT  = 3'd3;
  localparam logic [2:0] F_BELOW  = 3'd5;
  localparam logic [2:0] F_BRIGHT = 3'd1;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGBA5551 = 2'd1,
    FMT_RGBA4444 = 2'd2
  } fmt_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_OUT_FORMAT   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_e;

  typedef logic [7:0]       chan_t;
  typedef logic [ERR_W-1:0] err_t;

  // Position flags that travel with a pixel from the input register.
  typedef struct packed {
    logic last_col;
    logic last_row;
    logic row_nz;
  } pos_t;

  // One diffused term: error * factor / 16, at most six.
  function automatic logic [LANE_W-1:0] diffuse(input logic [3:0] err, input logic [2:0] fac);
    logic [6:0] prod;
    prod = 7'(err) * 7'(fac);
    return prod[6:4];
  endfunction

endpackage

[design/edpp_in_if.sv]
// Pixel input channel: four channel bytes with valid/ready.
interface edpp_in_if;
  logic  valid;
  logic  ready;
  logic [7:0] byte_0;
  logic [7:0] byte_1;
  logic [7:0] byte_2;
  logic [7:0] byte_3;

  modport source (output valid, output byte_0, output byte_1, output byte_2,
                  output byte_3, input ready);
  modport sink   (input valid, input byte_0, input byte_1, input byte_2,
                  input byte_3, output ready);
endinterface

[design/edpp_out_if.sv]
// Packed pixel output channel with valid/ready.
interface edpp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] packed_pixel;
  logic        frame_end;

  modport source (output valid, output packed_pixel, output frame_end, input ready);
  modport sink   (input valid, input packed_pixel, input frame_end, output ready);
endinterface

[design/edpp_line_store.sv]
// Next-row error line store: one write port, one registered read with write forwarding.
module edpp_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  edpp_pkg::err_t       wdata_i,
  output edpp_pkg::err_t       rdata_o
);

  edpp_pkg::err_t mem [DEPTH];
  edpp_pkg::err_t mem_rd_q;
  edpp_pkg::err_t fwd_data_q;
  logic           fwd_hit_q;
  logic [AW-1:0]  raddr_q;

  // Keep the held read word current: a later write to the same entry replaces it.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      raddr_q    <= raddr_i;
      mem_rd_q   <= mem[raddr_i];
      fwd_hit_q  <= we_i && (waddr_i == raddr_i);
      fwd_data_q <= wdata_i;
    end else if (we_i && (waddr_i == raddr_q)) begin
      fwd_hit_q  <= 1'b1;
      fwd_data_q <= wdata_i;
    end
  end

  assign rdata_o = fwd_hit_q ? fwd_data_q : mem_rd_q;

endmodule

[design/edpp_quant.sv]
// Per-pixel correction, saturation, packing and error term spreading.
module edpp_quant (
  input  edpp_pkg::chan_t                   chan_i [edpp_pkg::NUM_CH],
  input  edpp_pkg::err_t                    right_i,
  input  edpp_pkg::err_t                    below_i,
  input  logic [edpp_pkg::FMT_W-1:0]        fmt_i,
  output logic [15:0]                       packed_o,
  output edpp_pkg::err_t                    t7_o,
  output edpp_pkg::err_t                    t5_o,
  output edpp_pkg::err_t                    t3_o,
  output edpp_pkg::err_t                    t1_o
);

  localparam int unsigned LW = edpp_pkg::LANE_W;

  logic [8:0]  sum [edpp_pkg::NUM_CH];
  logic [7:0]  v   [edpp_pkg::NUM_CH];
  logic [3:0]  e   [edpp_pkg::NUM_CH];

  // Add both carried terms and saturate once.
  always_comb begin
    for (int c = 0; c < int'(edpp_pkg::NUM_CH); c++) begin
      sum[c] = 9'(chan_i[c]) + 9'(right_i[LW*c +: LW]) + 9'(below_i[LW*c +: LW]);
      v[c]   = sum[c][8] ? 8'hff : sum[c][7:0];
    end
  end

  always_comb begin
    unique case (fmt_i)
      edpp_pkg::FMT_RGB565: begin
        packed_o = {v[0][7:3], v[1][7:2], v[2][7:3]};
        e[0] = {1'b0, v[0][2:0]};
        e[1] = {2'b00, v[1][1:0]};
        e[2] = {1'b0, v[2][2:0]};
        e[3] = 4'd0;
      end
      edpp_pkg::FMT_RGBA5551: begin
        packed_o = {v[0][7:3], v[1][7:3], v[2][7:3], v[3][7]};
        for (int c = 0; c < int'(edpp_pkg::NUM_CH); c++) begin
          e[c] = {1'b0, v[c][2:0]};
        end
      end
      default: begin
        packed_o = {v[0][7:4], v[1][7:4], v[2][7:4], v[3][7:4]};
        for (int c = 0; c < int'(edpp_pkg::NUM_CH); c++) begin
          e[c] = v[c][3:0];
        end
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < int'(edpp_pkg::NUM_CH); c++) begin
      t7_o[LW*c +: LW] = edpp_pkg::diffuse(e[c], edpp_pkg::F_RIGHT);
      t5_o[LW*c +: LW] = edpp_pkg::diffuse(e[c], edpp_pkg::F_BELOW);
      t3_o[LW*c +: LW] = edpp_pkg::diffuse(e[c], edpp_pkg::F_BLEFT);
      t1_o[LW*c +: LW] = edpp_pkg::diffuse(e[c], edpp_pkg::F_BRIGHT);
    end
  end

endmodule

[design/error_diffusion_pixel_packer_core.sv]
// Top level of the error diffusion pixel packer.
//
// Usage: pixels enter on pix_i in raster order, one word of four channel
// bytes each; one packed 16-bit word per pixel leaves on word_o, with
// frame_end high on the last pixel of a frame. Words are accepted when valid
// and ready are both high. Format, width and height are written through the
// cfg_* port while no pixel is in flight.
// Pipeline: an accepted pixel passes the input register (with the line store
// read), then the quantizer into the output register.
// Throughput: one pixel per cycle unless word_o stalls. The right-neighbor carry
// closes through the quantizer into its register; the line store takes one write
// per cycle, the second write of a row end waits in a one-entry tail buffer until
// the next free port cycle (the following column-0 pixel or any idle cycle).
// Reset: counters, carries, the pipeline and the config registers clear
// (rgb565, width 1, height 1). The line store is not cleared: row 0 of every
// frame ignores it and every later row reads only what the row above wrote.
// Stall: when word_o is not taken the output holds, one more pixel can still
// wait in the input register, then pix_i.ready drops.
module error_diffusion_pixel_packer_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  edpp_in_if.sink                       pix_i,
  edpp_out_if.source                    word_o,
  input  logic                          cfg_we_i,
  input  logic [edpp_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [edpp_pkg::CFG_DW-1:0]   cfg_wdata_i
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = (AW + 1 > edpp_pkg::IMG_WW) ? AW + 1 : edpp_pkg::IMG_WW;
  localparam int unsigned HCW = edpp_pkg::IMG_HW + 1;

  // Configuration registers.
  logic [edpp_pkg::FMT_W-1:0]  fmt_q;
  logic [edpp_pkg::IMG_WW-1:0] width_q;
  logic [edpp_pkg::IMG_HW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= edpp_pkg::FMT_RGB565;
      width_q  <= edpp_pkg::IMG_WW'(1);
      height_q <= edpp_pkg::IMG_HW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        edpp_pkg::REG_OUT_FORMAT:   fmt_q    <= cfg_wdata_i[edpp_pkg::FMT_W-1:0];
        edpp_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[edpp_pkg::IMG_WW-1:0];
        edpp_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[edpp_pkg::IMG_HW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic accept;
  logic advance;
  logic s1_valid_q;
  logic out_valid_q;

  assign advance     = s1_valid_q && (!out_valid_q || word_o.ready);
  assign pix_i.ready = !s1_valid_q || !out_valid_q || word_o.ready;
  assign accept      = pix_i.valid && pix_i.ready;

  // Position counters: advance at accept, depend only on config.
  logic [AW-1:0]         col_q;
  logic [HCW-2:0]        row_q;
  logic [WCW-1:0]        width_ext;
  logic [WCW-1:0]        eff_w;
  logic [HCW-1:0]        eff_h;
  edpp_pkg::pos_t        pos;

  always_comb begin
    width_ext = WCW'(width_q);
    if (width_ext == '0) begin
      eff_w = WCW'(1);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    eff_h        = (height_q == '0) ? HCW'(1) : HCW'(height_q);
    pos.last_col = (WCW'(col_q) + WCW'(1)) >= eff_w;
    pos.last_row = (HCW'(row_q) + HCW'(1)) >= eff_h;
    pos.row_nz   = (row_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (pos.last_col) begin
        col_q <= '0;
        row_q <= pos.last_row ? '0 : (HCW-1)'(row_q + 1'b1);
      end else begin
        col_q <= AW'(col_q + 1'b1);
      end
    end
  end

  // Input register; the line store read for the same column lands alongside.
  edpp_pkg::chan_t s1_chan_q [edpp_pkg::NUM_CH];
  logic [AW-1:0]   s1_col_q;
  edpp_pkg::pos_t  s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_chan_q[0] <= pix_i.byte_0;
      s1_chan_q[1] <= pix_i.byte_1;
      s1_chan_q[2] <= pix_i.byte_2;
      s1_chan_q[3] <= pix_i.byte_3;
      s1_col_q     <= col_q;
      s1_pos_q     <= pos;
    end
  end

  // Diffusion state: right carry and the two open next-row sums.
  edpp_pkg::err_t right_q;
  edpp_pkg::err_t pend_lo_q;
  edpp_pkg::err_t pend_hi_q;

  // Row-end tail write, held until the store port is free.
  logic           tail_valid_q;
  logic [AW-1:0]  tail_addr_q;
  edpp_pkg::err_t tail_data_q;

  // Line store port signals.
  logic           ls_we;
  logic [AW-1:0]  ls_waddr;
  edpp_pkg::err_t ls_wdata;
  edpp_pkg::err_t ls_rdata;

  edpp_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (col_q),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .rdata_o (ls_rdata)
  );

  // Pick the newest copy of the error from the row above; row 0 reads none.
  edpp_pkg::err_t below;
  always_comb begin
    priority if (!s1_pos_q.row_nz) begin
      below = '0;
    end else if (tail_valid_q && (tail_addr_q == s1_col_q)) begin
      below = tail_data_q;
    end else begin
      below = ls_rdata;
    end
  end

  logic [15:0]    packed_pix;
  edpp_pkg::err_t t7;
  edpp_pkg::err_t t5;
  edpp_pkg::err_t t3;
  edpp_pkg::err_t t1;

  edpp_quant u_quant (
    .chan_i   (s1_chan_q),
    .right_i  (right_q),
    .below_i  (below),
    .fmt_i    (fmt_q),
    .packed_o (packed_pix),
    .t7_o     (t7),
    .t5_o     (t5),
    .t3_o     (t3),
    .t1_o     (t1)
  );

  // Lane sums stay small, so packed adds never carry between lanes.
  edpp_pkg::err_t sum_left;
  edpp_pkg::err_t sum_here;
  logic           wr_left;

  assign sum_left = pend_lo_q + t3;
  assign sum_here = pend_hi_q + t5;
  assign wr_left  = advance && (s1_col_q != '0);

  // Store port: the lower-left completion has priority, else drain the tail.
  always_comb begin
    ls_we    = wr_left || tail_valid_q;
    ls_waddr = wr_left ? AW'(s1_col_q - AW'(1)) : tail_addr_q;
    ls_wdata = wr_left ? sum_left : tail_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_valid_q <= 1'b0;
    end else if (advance && s1_pos_q.last_col) begin
      tail_valid_q <= 1'b1;
    end else if (!wr_left) begin
      tail_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_pos_q.last_col) begin
      tail_addr_q <= s1_col_q;
      tail_data_q <= sum_here;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q   <= '0;
      pend_lo_q <= '0;
      pend_hi_q <= '0;
    end else if (advance) begin
      if (s1_pos_q.last_col) begin
        // Drop everything that would cross the row edge.
        right_q   <= '0;
        pend_lo_q <= '0;
        pend_hi_q <= '0;
      end else begin
        right_q   <= t7;
        pend_lo_q <= sum_here;
        pend_hi_q <= t1;
      end
    end
  end

  // Output register.
  logic [15:0] out_pixel_q;
  logic        out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (word_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pixel_q <= packed_pix;
      out_end_q   <= s1_pos_q.last_col && s1_pos_q.last_row;
    end
  end

  assign word_o.valid        = out_valid_q;
  assign word_o.packed_pixel = out_pixel_q;
  assign word_o.frame_end    = out_end_q;

endmodule
